>>> hdl/llts_pkg.sv
// Shared types, codes and character constants for the line lexer token stream.
`timescale 1ns / 1ps
`default_nettype none

package llts_pkg;

  // Default sizes handed to the top level.
  localparam int LINE_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Integer token values are 63 bits wide and limited to 2^63-1.
  localparam int                 NUM_BITS  = 63;
  localparam logic [NUM_BITS-1:0] VALUE_MAX = '1;

  // Characters the lexer looks for.
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N_LOWER   = 8'h6E;
  localparam logic [7:0] CH_T_LOWER   = 8'h74;
  localparam logic [7:0] CH_X_LOWER   = 8'h78;
  localparam logic [7:0] CH_X_UPPER   = 8'h58;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_A_LOWER   = 8'h61;
  localparam logic [7:0] CH_F_LOWER   = 8'h66;
  localparam logic [7:0] CH_A_UPPER   = 8'h41;
  localparam logic [7:0] CH_F_UPPER   = 8'h46;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Token kinds carried in each result.
  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_INT    = 3'd1,
    KIND_SYMBOL = 3'd2,
    KIND_STRING = 3'd3,
    KIND_ERROR  = 3'd4
  } token_kind_t;

  // Error codes carried in error results.
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNTERMINATED = 2'd1,
    ERR_BAD_ESCAPE   = 2'd2,
    ERR_RANGE        = 2'd3
  } error_code_t;

  // Lexer modes between input bytes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_COMMENT = 3'd5
  } lex_mode_t;

  // Radix of the integer being read.
  typedef enum logic [1:0] {
    RADIX_8  = 2'd0,
    RADIX_10 = 2'd1,
    RADIX_16 = 2'd2
  } radix_t;

  // Where the integer reader stands in its prefix.
  typedef enum logic [1:0] {
    POS_NONE       = 2'd0,
    POS_AFTER_ZERO = 2'd1,
    POS_DIGITS     = 2'd2,
    POS_AFTER_X    = 2'd3
  } digit_pos_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    token_kind_t         token_kind;
    logic [7:0]          char_value;
    logic                has_char;
    logic [NUM_BITS-1:0] number_value;
    logic                last_of_token;
    logic [15:0]         line_number;
    error_code_t         error_code;
  } result_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t entry0;
    result_t entry1;
  } queue_write_t;

endpackage

`default_nettype wire

>>> hdl/llts_front.sv
// Front end: classifies each text byte, tracks the token state and emits results.
`timescale 1ns / 1ps
`default_nettype none

module llts_front #(
  parameter int LINE_BITS = llts_pkg::LINE_BITS_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    accept,
  input  llts_pkg::in_item_t     item,
  output llts_pkg::queue_write_t wr
);

  localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= llts_pkg::CH_ZERO && c <= llts_pkg::CH_NINE) begin
        v = c - llts_pkg::CH_ZERO;
        return {1'b1, v[3:0]};
      end else if (c >= llts_pkg::CH_A_LOWER && c <= llts_pkg::CH_F_LOWER) begin
        v = c - llts_pkg::CH_A_LOWER + 8'd10;
        return {1'b1, v[3:0]};
      end else if (c >= llts_pkg::CH_A_UPPER && c <= llts_pkg::CH_F_UPPER) begin
        v = c - llts_pkg::CH_A_UPPER + 8'd10;
        return {1'b1, v[3:0]};
      end
      return 5'd0;
    end
  endfunction

  // Builds one result record.
  function automatic llts_pkg::result_t make_result(
    input llts_pkg::token_kind_t        kind,
    input logic [7:0]                   ch,
    input logic                         has,
    input logic [llts_pkg::NUM_BITS-1:0] num,
    input logic                         last,
    input llts_pkg::error_code_t        err,
    input logic [15:0]                  line
  );
    llts_pkg::result_t r;
    begin
      r.token_kind    = kind;
      r.char_value    = ch;
      r.has_char      = has;
      r.number_value  = num;
      r.last_of_token = last;
      r.line_number   = line;
      r.error_code    = err;
      return r;
    end
  endfunction

  // Lexer state.
  llts_pkg::lex_mode_t           mode, mode_next;
  logic [7:0]                    held_char, held_char_next;
  logic                          held_valid, held_valid_next;
  logic [llts_pkg::NUM_BITS-1:0] accum, accum_next;
  llts_pkg::radix_t              radix, radix_next;
  llts_pkg::digit_pos_t          dpos, dpos_next;
  logic                          stopped, stopped_next;
  logic                          overflow, overflow_next;
  logic [LINE_BITS-1:0]          line_counter, line_counter_next;
  logic                          halted, halted_next;

  // Byte classification.
  logic [7:0] c;
  logic       is_space, is_punct, is_digit;
  logic [4:0] dig;
  logic [LW-1:0] line_wide;
  logic [15:0]   line_out;

  assign c         = item.char_code;
  assign is_space  = (c == llts_pkg::CH_SPACE) || (c >= llts_pkg::CH_TAB && c <= llts_pkg::CH_CR);
  assign is_punct  = (c == llts_pkg::CH_COMMA) || (c == llts_pkg::CH_LPAREN) ||
                     (c == llts_pkg::CH_RPAREN) || (c == llts_pkg::CH_DOT);
  assign is_digit  = (c >= llts_pkg::CH_ZERO) && (c <= llts_pkg::CH_NINE);
  assign dig       = hex_digit(c);

  // Line number as reported, clamped to 16 bits.
  assign line_wide = LW'(line_counter);
  assign line_out  = (line_wide > LW'(16'hFFFF)) ? 16'hFFFF : line_wide[15:0];

  // The result that ends an identifier or integer in progress.
  logic              word_valid, word_error;
  llts_pkg::result_t word_entry;

  always_comb begin
    word_valid = 1'b0;
    word_error = 1'b0;
    word_entry = make_result(llts_pkg::KIND_IDENT, held_char, 1'b1, '0, 1'b1,
                             llts_pkg::ERR_NONE, line_out);
    if (mode == llts_pkg::MODE_IDENT) begin
      word_valid = held_valid;
    end else if (mode == llts_pkg::MODE_NUMBER) begin
      word_valid = 1'b1;
      if (overflow) begin
        word_error = 1'b1;
        word_entry = make_result(llts_pkg::KIND_ERROR, 8'd0, 1'b0, '0, 1'b1,
                                 llts_pkg::ERR_RANGE, line_out);
      end else begin
        word_entry = make_result(llts_pkg::KIND_INT, 8'd0, 1'b0, accum, 1'b1,
                                 llts_pkg::ERR_NONE, line_out);
      end
    end
  end

  // Integer accumulation: one constant-radix multiply-add with a range check.
  logic [llts_pkg::NUM_BITS-1:0] acc_accum;
  llts_pkg::radix_t              acc_radix, eff_radix;
  llts_pkg::digit_pos_t          acc_pos;
  logic                          acc_stop, acc_ovf, check;
  logic [4:0]                    radix_limit;
  logic [llts_pkg::NUM_BITS+3:0] acc_wide, product, sum;

  always_comb begin
    acc_wide = {4'd0, accum};
    unique case (eff_radix)
      llts_pkg::RADIX_8:  product = acc_wide << 3;
      llts_pkg::RADIX_16: product = acc_wide << 4;
      default:            product = (acc_wide << 3) + (acc_wide << 1);
    endcase
    sum = product + (llts_pkg::NUM_BITS + 4)'(dig[3:0]);
  end

  always_comb begin
    acc_accum = accum;
    acc_radix = radix;
    acc_pos   = dpos;
    acc_stop  = stopped;
    acc_ovf   = overflow;
    eff_radix = radix;
    check     = 1'b0;
    if (!stopped) begin
      unique case (dpos)
        llts_pkg::POS_AFTER_ZERO: begin
          if (c == llts_pkg::CH_X_LOWER || c == llts_pkg::CH_X_UPPER) begin
            acc_radix = llts_pkg::RADIX_16;
            acc_pos   = llts_pkg::POS_AFTER_X;
          end else begin
            acc_radix = llts_pkg::RADIX_8;
            acc_pos   = llts_pkg::POS_DIGITS;
            eff_radix = llts_pkg::RADIX_8;
            check     = 1'b1;
          end
        end
        llts_pkg::POS_AFTER_X: begin
          if (dig[4]) begin
            acc_accum = llts_pkg::NUM_BITS'(dig[3:0]);
            acc_pos   = llts_pkg::POS_DIGITS;
          end else begin
            acc_stop = 1'b1;
          end
        end
        default: check = 1'b1;
      endcase
    end
    unique case (eff_radix)
      llts_pkg::RADIX_8:  radix_limit = 5'd8;
      llts_pkg::RADIX_16: radix_limit = 5'd16;
      default:            radix_limit = 5'd10;
    endcase
    if (check) begin
      if (!dig[4] || ({1'b0, dig[3:0]} >= radix_limit)) begin
        acc_stop = 1'b1;
      end else if (!overflow) begin
        if (sum > {4'd0, llts_pkg::VALUE_MAX}) begin
          acc_ovf = 1'b1;
        end else begin
          acc_accum = sum[llts_pkg::NUM_BITS-1:0];
        end
      end
    end
  end

  // Escape translation inside strings.
  logic [7:0] esc_char;
  logic       esc_ok;

  always_comb begin
    esc_ok   = 1'b1;
    esc_char = c;
    if (c == llts_pkg::CH_N_LOWER) begin
      esc_char = llts_pkg::CH_NEWLINE;
    end else if (c == llts_pkg::CH_T_LOWER) begin
      esc_char = llts_pkg::CH_TAB;
    end else if (c != llts_pkg::CH_BACKSLASH && c != llts_pkg::CH_QUOTE) begin
      esc_ok = 1'b0;
    end
  end

  // Next state and results for one accepted transaction.
  always_comb begin
    mode_next         = mode;
    held_char_next    = held_char;
    held_valid_next   = held_valid;
    accum_next        = accum;
    radix_next        = radix;
    dpos_next         = dpos;
    stopped_next      = stopped;
    overflow_next     = overflow;
    line_counter_next = line_counter;
    halted_next       = halted;
    wr                = '0;

    if (accept && !halted) begin
      if (item.line_end) begin
        // End of line closes words and is an error inside a string.
        held_valid_next = 1'b0;
        mode_next       = llts_pkg::MODE_IDLE;
        if (line_counter != '1) begin
          line_counter_next = line_counter + 1'b1;
        end
        if (mode == llts_pkg::MODE_STRING || mode == llts_pkg::MODE_ESCAPE) begin
          wr.valid0   = 1'b1;
          wr.entry0   = make_result(llts_pkg::KIND_ERROR, 8'd0, 1'b0, '0, 1'b1,
                                    llts_pkg::ERR_UNTERMINATED, line_out);
          halted_next = 1'b1;
        end else begin
          wr.valid0   = word_valid;
          wr.entry0   = word_entry;
          halted_next = word_error;
        end
      end else begin
        unique case (mode)
          llts_pkg::MODE_COMMENT: begin
          end
          llts_pkg::MODE_STRING: begin
            if (c == llts_pkg::CH_QUOTE) begin
              wr.valid0       = 1'b1;
              wr.entry0       = make_result(llts_pkg::KIND_STRING,
                                            held_valid ? held_char : 8'd0, held_valid,
                                            '0, 1'b1, llts_pkg::ERR_NONE, line_out);
              held_valid_next = 1'b0;
              mode_next       = llts_pkg::MODE_IDLE;
            end else if (c == llts_pkg::CH_BACKSLASH) begin
              mode_next = llts_pkg::MODE_ESCAPE;
            end else begin
              wr.valid0       = held_valid;
              wr.entry0       = make_result(llts_pkg::KIND_STRING, held_char, 1'b1, '0,
                                            1'b0, llts_pkg::ERR_NONE, line_out);
              held_char_next  = c;
              held_valid_next = 1'b1;
            end
          end
          llts_pkg::MODE_ESCAPE: begin
            if (esc_ok) begin
              wr.valid0       = held_valid;
              wr.entry0       = make_result(llts_pkg::KIND_STRING, held_char, 1'b1, '0,
                                            1'b0, llts_pkg::ERR_NONE, line_out);
              held_char_next  = esc_char;
              held_valid_next = 1'b1;
              mode_next       = llts_pkg::MODE_STRING;
            end else begin
              wr.valid0       = 1'b1;
              wr.entry0       = make_result(llts_pkg::KIND_ERROR, 8'd0, 1'b0, '0, 1'b1,
                                            llts_pkg::ERR_BAD_ESCAPE, line_out);
              halted_next     = 1'b1;
              held_valid_next = 1'b0;
              mode_next       = llts_pkg::MODE_IDLE;
            end
          end
          llts_pkg::MODE_IDENT, llts_pkg::MODE_NUMBER: begin
            if (is_space || is_punct || c == llts_pkg::CH_HASH) begin
              // The word ends; a symbol adds its own result, a hash opens a comment.
              wr.valid0       = word_valid;
              wr.entry0       = word_entry;
              halted_next     = word_error;
              held_valid_next = 1'b0;
              mode_next       = llts_pkg::MODE_IDLE;
              if (!word_error) begin
                if (is_punct) begin
                  wr.valid1 = 1'b1;
                  wr.entry1 = make_result(llts_pkg::KIND_SYMBOL, c, 1'b1, '0, 1'b1,
                                          llts_pkg::ERR_NONE, line_out);
                end else if (c == llts_pkg::CH_HASH) begin
                  mode_next = llts_pkg::MODE_COMMENT;
                end
              end
            end else if (mode == llts_pkg::MODE_IDENT) begin
              wr.valid0       = 1'b1;
              wr.entry0       = make_result(llts_pkg::KIND_IDENT, held_char, 1'b1, '0,
                                            1'b0, llts_pkg::ERR_NONE, line_out);
              held_char_next  = c;
              held_valid_next = 1'b1;
            end else begin
              accum_next    = acc_accum;
              radix_next    = acc_radix;
              dpos_next     = acc_pos;
              stopped_next  = acc_stop;
              overflow_next = acc_ovf;
            end
          end
          default: begin
            // Between tokens: pick what kind of token this byte opens.
            mode_next = llts_pkg::MODE_IDLE;
            if (is_space) begin
            end else if (c == llts_pkg::CH_QUOTE) begin
              held_valid_next = 1'b0;
              mode_next       = llts_pkg::MODE_STRING;
            end else if (is_punct) begin
              wr.valid0 = 1'b1;
              wr.entry0 = make_result(llts_pkg::KIND_SYMBOL, c, 1'b1, '0, 1'b1,
                                      llts_pkg::ERR_NONE, line_out);
            end else if (is_digit) begin
              accum_next    = llts_pkg::NUM_BITS'(dig[3:0]);
              radix_next    = llts_pkg::RADIX_10;
              dpos_next     = (c == llts_pkg::CH_ZERO) ? llts_pkg::POS_AFTER_ZERO
                                                       : llts_pkg::POS_DIGITS;
              stopped_next  = 1'b0;
              overflow_next = 1'b0;
              mode_next     = llts_pkg::MODE_NUMBER;
            end else begin
              held_char_next  = c;
              held_valid_next = 1'b1;
              mode_next       = llts_pkg::MODE_IDENT;
            end
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= llts_pkg::MODE_IDLE;
      held_char    <= 8'd0;
      held_valid   <= 1'b0;
      accum        <= '0;
      radix        <= llts_pkg::RADIX_10;
      dpos         <= llts_pkg::POS_NONE;
      stopped      <= 1'b0;
      overflow     <= 1'b0;
      line_counter <= LINE_BITS'(1);
      halted       <= 1'b0;
    end else begin
      mode         <= mode_next;
      held_char    <= held_char_next;
      held_valid   <= held_valid_next;
      accum        <= accum_next;
      radix        <= radix_next;
      dpos         <= dpos_next;
      stopped      <= stopped_next;
      overflow     <= overflow_next;
      line_counter <= line_counter_next;
      halted       <= halted_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/llts_queue.sv
// Back end: result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module llts_queue #(
  parameter int DEPTH = llts_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst,
  input  llts_pkg::queue_write_t wr,
  output logic                   full,
  output logic                   empty,
  input  wire                    pop,
  output llts_pkg::result_t      result
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  llts_pkg::result_t entries [DEPTH];
  logic [PW-1:0]     head, tail, tail_plus1;
  logic [CW-1:0]     count;
  logic              pop_ok, we_a, we_b;
  logic [1:0]        n_wr;
  llts_pkg::result_t data_a;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    begin
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    end
  endfunction

  // Write side: the first valid result goes to the tail, a second one after it.
  assign tail_plus1 = wrap_inc(tail);
  assign we_a       = wr.valid0 | wr.valid1;
  assign we_b       = wr.valid0 & wr.valid1;
  assign data_a     = wr.valid0 ? wr.entry0 : wr.entry1;
  assign n_wr       = {1'b0, wr.valid0} + {1'b0, wr.valid1};

  // Read side and status.
  assign pop_ok = pop && !empty;
  assign empty  = (count == '0);
  assign full   = (count > CW'(DEPTH - 2));
  assign result = entries[head];

  always_ff @(posedge clk) begin
    if (we_a) begin
      entries[tail] <= data_a;
    end
    if (we_b) begin
      entries[tail_plus1] <= wr.entry1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop_ok) begin
        head <= wrap_inc(head);
      end
      if (we_b) begin
        tail <= wrap_inc(tail_plus1);
      end else if (we_a) begin
        tail <= tail_plus1;
      end
      count <= count + CW'(n_wr) - CW'(pop_ok);
    end
  end

endmodule

`default_nettype wire

>>> hdl/line_lexer_token_stream_core.sv
// A byte's results are written into the queue at the clock edge that accepts the byte.
// Throughput: one byte per cycle; full rises while fewer than two queue slots are free, and
// results leave the queue one per cycle, so bytes that give two results drain at one per cycle.
// After an error result the lexer halts and takes bytes without producing results until reset.
// Reset is synchronous: it empties the queue, clears the lexer state and sets the line to one.
// Top level of the line lexer token stream: front lexer feeding the result queue.
`timescale 1ns / 1ps
`default_nettype none

module line_lexer_token_stream_core #(
  parameter int LINE_BITS   = llts_pkg::LINE_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = llts_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  llts_pkg::in_item_t item,
  output logic               empty,
  input  wire                pop,
  output llts_pkg::result_t  result
);

  llts_pkg::queue_write_t wr;
  logic                   accept;

  // An input transaction completes when push meets a queue with room for two results.
  assign accept = push && !full;

  llts_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .wr     (wr)
  );

  llts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

>>> hdl/llts_checker.sv
// Port-level checks on the line lexer token stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module llts_checker (
  input wire               clk,
  input wire               rst,
  input wire               full,
  input wire               empty,
  input wire               pop,
  input llts_pkg::result_t result
);

  // Reset leaves an empty queue that can take a transaction.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not empty or still full after reset");

  // A waiting result that is not taken stays in place.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

  // Error results and only they carry an error code.
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.token_kind == llts_pkg::KIND_ERROR) ==
                (result.error_code != llts_pkg::ERR_NONE)))
    else $error("error code does not match token kind");

  // Integer, symbol and error results each close their token.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.token_kind == llts_pkg::KIND_INT ||
                result.token_kind == llts_pkg::KIND_SYMBOL ||
                result.token_kind == llts_pkg::KIND_ERROR)) |-> result.last_of_token)
    else $error("single-result token without last mark");

  // Only integer results carry a value.
  a_number_only_int: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.token_kind != llts_pkg::KIND_INT) |-> (result.number_value == '0))
    else $error("non-integer result with a number value");

endmodule

bind line_lexer_token_stream_core llts_checker u_llts_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

>>> tb/tb_line_lexer_token_stream_core.sv
// Self-checking testbench for the line lexer token stream core.
`timescale 1ns / 1ps

module tb_line_lexer_token_stream_core;

  localparam int            STALL_LIMIT    = 2000;
  localparam int            ROUND_ITEMS    = 200;
  localparam int            RANDOM_ROUNDS  = 8;
  localparam logic [15:0]   LINE_CEILING   = 16'hFFFF;
  localparam logic [63:0]   NUMBER_CEILING = {1'b0, llts_pkg::VALUE_MAX};

  // Lexer state kept by the predictor.
  typedef struct {
    llts_pkg::lex_mode_t  mode;
    logic [7:0]           held_ch;
    logic                 held_ok;
    logic [63:0]          acc;
    llts_pkg::radix_t     radix;
    llts_pkg::digit_pos_t pos;
    logic                 stopped;
    logic                 ovf;
    logic [15:0]          line_cnt;
    logic                 halted;
  } lexer_state_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  llts_pkg::in_item_t item = '0;
  logic               full;
  logic               empty;
  llts_pkg::result_t  result;

  lexer_state_t      lex;
  llts_pkg::result_t step_out[$];
  llts_pkg::result_t expected_tokens[$];
  int unsigned       gap_max = 6;
  int unsigned       stall_max = 6;
  int unsigned       items_sent = 0;
  int unsigned       quiet_cycles = 0;
  int                fail_count = 0;

  line_lexer_token_stream_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_lexer();
    lex.mode     = llts_pkg::MODE_IDLE;
    lex.held_ch  = '0;
    lex.held_ok  = 1'b0;
    lex.acc      = '0;
    lex.radix    = llts_pkg::RADIX_10;
    lex.pos      = llts_pkg::POS_NONE;
    lex.stopped  = 1'b0;
    lex.ovf      = 1'b0;
    lex.line_cnt = 16'd1;
    lex.halted   = 1'b0;
  endfunction

  function automatic void emit(llts_pkg::token_kind_t kind, logic [7:0] ch, logic has,
                               logic [llts_pkg::NUM_BITS-1:0] num, logic last,
                               llts_pkg::error_code_t code);
    llts_pkg::result_t r;
    r.token_kind    = kind;
    r.char_value    = ch;
    r.has_char      = has;
    r.number_value  = num;
    r.last_of_token = last;
    r.line_number   = lex.line_cnt;
    r.error_code    = code;
    step_out = {step_out, r};
  endfunction

  function automatic void halt_with_error(llts_pkg::error_code_t code);
    emit(llts_pkg::KIND_ERROR, 8'h00, 1'b0, '0, 1'b1, code);
    lex.halted  = 1'b1;
    lex.held_ok = 1'b0;
    lex.mode    = llts_pkg::MODE_IDLE;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == llts_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == llts_pkg::CH_COMMA || c == llts_pkg::CH_LPAREN ||
           c == llts_pkg::CH_RPAREN || c == llts_pkg::CH_DOT;
  endfunction

  function automatic logic [63:0] digit_of(logic [7:0] c);
    if (c >= llts_pkg::CH_ZERO && c <= llts_pkg::CH_NINE)
      return 64'(c - llts_pkg::CH_ZERO);
    if (c >= llts_pkg::CH_A_LOWER && c <= llts_pkg::CH_F_LOWER)
      return 64'(c - llts_pkg::CH_A_LOWER) + 64'd10;
    if (c >= llts_pkg::CH_A_UPPER && c <= llts_pkg::CH_F_UPPER)
      return 64'(c - llts_pkg::CH_A_UPPER) + 64'd10;
    return 64'd99;
  endfunction

  function automatic logic [63:0] radix_value(llts_pkg::radix_t r);
    case (r)
      llts_pkg::RADIX_8:  return 64'd8;
      llts_pkg::RADIX_16: return 64'd16;
      default:            return 64'd10;
    endcase
  endfunction

  // Adds one digit to the integer, handling the 0 and 0x prefixes.
  function automatic void accumulate(logic [7:0] c);
    logic [63:0] d;
    logic [63:0] base;
    if (lex.stopped) return;
    if (lex.pos == llts_pkg::POS_AFTER_ZERO) begin
      if (c == llts_pkg::CH_X_LOWER || c == llts_pkg::CH_X_UPPER) begin
        lex.radix = llts_pkg::RADIX_16;
        lex.pos   = llts_pkg::POS_AFTER_X;
        return;
      end
      lex.radix = llts_pkg::RADIX_8;
      lex.pos   = llts_pkg::POS_DIGITS;
    end else if (lex.pos == llts_pkg::POS_AFTER_X) begin
      d = digit_of(c);
      if (d < 64'd16) begin
        lex.acc = d;
        lex.pos = llts_pkg::POS_DIGITS;
      end else begin
        lex.stopped = 1'b1;
      end
      return;
    end
    d    = digit_of(c);
    base = radix_value(lex.radix);
    if (d >= base) begin
      lex.stopped = 1'b1;
      return;
    end
    if (lex.ovf) return;
    if (lex.acc > (NUMBER_CEILING - d) / base) lex.ovf = 1'b1;
    else lex.acc = lex.acc * base + d;
  endfunction

  // Closes an identifier or integer; returns 0 when the integer was out of range.
  function automatic bit end_word();
    if (lex.mode == llts_pkg::MODE_IDENT) begin
      if (lex.held_ok)
        emit(llts_pkg::KIND_IDENT, lex.held_ch, 1'b1, '0, 1'b1, llts_pkg::ERR_NONE);
      lex.held_ok = 1'b0;
    end else if (lex.mode == llts_pkg::MODE_NUMBER) begin
      if (lex.ovf) begin
        halt_with_error(llts_pkg::ERR_RANGE);
        return 1'b0;
      end
      emit(llts_pkg::KIND_INT, 8'h00, 1'b0, lex.acc[llts_pkg::NUM_BITS-1:0], 1'b1,
           llts_pkg::ERR_NONE);
    end
    lex.mode = llts_pkg::MODE_IDLE;
    return 1'b1;
  endfunction

  // String characters are held back one step so the last one can be marked.
  function automatic void add_string_char(logic [7:0] c);
    if (lex.held_ok)
      emit(llts_pkg::KIND_STRING, lex.held_ch, 1'b1, '0, 1'b0, llts_pkg::ERR_NONE);
    lex.held_ch = c;
    lex.held_ok = 1'b1;
  endfunction

  // Advances the lexer by one transaction and appends its results to step_out.
  function automatic void lex_byte(llts_pkg::in_item_t it);
    logic [7:0] c;
    c = it.char_code;
    if (lex.halted) return;

    if (it.line_end) begin
      if (lex.mode == llts_pkg::MODE_STRING || lex.mode == llts_pkg::MODE_ESCAPE)
        halt_with_error(llts_pkg::ERR_UNTERMINATED);
      else void'(end_word());
      lex.held_ok = 1'b0;
      if (lex.line_cnt != LINE_CEILING) lex.line_cnt = lex.line_cnt + 16'd1;
      return;
    end

    case (lex.mode)
      llts_pkg::MODE_COMMENT: begin
      end
      llts_pkg::MODE_STRING: begin
        if (c == llts_pkg::CH_QUOTE) begin
          if (lex.held_ok)
            emit(llts_pkg::KIND_STRING, lex.held_ch, 1'b1, '0, 1'b1, llts_pkg::ERR_NONE);
          else
            emit(llts_pkg::KIND_STRING, 8'h00, 1'b0, '0, 1'b1, llts_pkg::ERR_NONE);
          lex.held_ok = 1'b0;
          lex.mode    = llts_pkg::MODE_IDLE;
        end else if (c == llts_pkg::CH_BACKSLASH) begin
          lex.mode = llts_pkg::MODE_ESCAPE;
        end else begin
          add_string_char(c);
        end
      end
      llts_pkg::MODE_ESCAPE: begin
        if (c == llts_pkg::CH_N_LOWER) begin
          add_string_char(llts_pkg::CH_NEWLINE);
          lex.mode = llts_pkg::MODE_STRING;
        end else if (c == llts_pkg::CH_T_LOWER) begin
          add_string_char(llts_pkg::CH_TAB);
          lex.mode = llts_pkg::MODE_STRING;
        end else if (c == llts_pkg::CH_BACKSLASH || c == llts_pkg::CH_QUOTE) begin
          add_string_char(c);
          lex.mode = llts_pkg::MODE_STRING;
        end else begin
          halt_with_error(llts_pkg::ERR_BAD_ESCAPE);
        end
      end
      llts_pkg::MODE_IDENT, llts_pkg::MODE_NUMBER: begin
        if (is_space(c)) begin
          void'(end_word());
        end else if (is_punct(c)) begin
          if (end_word())
            emit(llts_pkg::KIND_SYMBOL, c, 1'b1, '0, 1'b1, llts_pkg::ERR_NONE);
        end else if (c == llts_pkg::CH_HASH) begin
          if (end_word()) lex.mode = llts_pkg::MODE_COMMENT;
        end else if (lex.mode == llts_pkg::MODE_IDENT) begin
          emit(llts_pkg::KIND_IDENT, lex.held_ch, 1'b1, '0, 1'b0, llts_pkg::ERR_NONE);
          lex.held_ch = c;
          lex.held_ok = 1'b1;
        end else begin
          accumulate(c);
        end
      end
      default: begin
        lex.mode = llts_pkg::MODE_IDLE;
        if (is_space(c)) begin
        end else if (c == llts_pkg::CH_QUOTE) begin
          lex.held_ok = 1'b0;
          lex.mode    = llts_pkg::MODE_STRING;
        end else if (is_punct(c)) begin
          emit(llts_pkg::KIND_SYMBOL, c, 1'b1, '0, 1'b1, llts_pkg::ERR_NONE);
        end else if (c >= llts_pkg::CH_ZERO && c <= llts_pkg::CH_NINE) begin
          lex.acc     = 64'(c - llts_pkg::CH_ZERO);
          lex.radix   = llts_pkg::RADIX_10;
          lex.pos     = (c == llts_pkg::CH_ZERO) ? llts_pkg::POS_AFTER_ZERO
                                                 : llts_pkg::POS_DIGITS;
          lex.stopped = 1'b0;
          lex.ovf     = 1'b0;
          lex.mode    = llts_pkg::MODE_NUMBER;
        end else begin
          lex.held_ch = c;
          lex.held_ok = 1'b1;
          lex.mode    = llts_pkg::MODE_IDENT;
        end
      end
    endcase
  endfunction

  // True when the transaction would lead to an error, now or when the integer ends.
  function automatic bit leads_to_error(llts_pkg::in_item_t it);
    lexer_state_t saved;
    bit           hit;
    saved = lex;
    lex_byte(it);
    hit = lex.halted || lex.ovf;
    lex = saved;
    step_out.delete();
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sends one transaction after a random gap and records its expected results.
  task automatic send_item(llts_pkg::in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (lex.mode != llts_pkg::MODE_COMMENT || it.line_end) items_sent++;
    step_out.delete();
    lex_byte(it);
    foreach (step_out[i]) expected_tokens = {expected_tokens, step_out[i]};
  endtask

  task automatic send_char(logic [7:0] c);
    llts_pkg::in_item_t it;
    it.char_code = c;
    it.line_end  = 1'b0;
    send_item(it);
  endtask

  task automatic send_eol();
    llts_pkg::in_item_t it;
    it.char_code = 8'($urandom_range(0, 255));
    it.line_end  = 1'b1;
    send_item(it);
  endtask

  // Replaces a transaction that would halt the lexer by one that keeps it going.
  task automatic send_guarded(llts_pkg::in_item_t it);
    if (leads_to_error(it)) begin
      it.line_end = 1'b0;
      case (lex.mode)
        llts_pkg::MODE_ESCAPE: it.char_code = llts_pkg::CH_N_LOWER;
        llts_pkg::MODE_NUMBER: it.char_code = 8'h7A;
        default:               it.char_code = llts_pkg::CH_QUOTE;
      endcase
    end
    send_item(it);
  endtask

  // A line end, swapped for a byte that keeps the lexer going if it would raise an error.
  task automatic send_guarded_eol();
    llts_pkg::in_item_t it;
    it.char_code = 8'($urandom_range(0, 255));
    it.line_end  = 1'b1;
    send_guarded(it);
  endtask

  task automatic send_text(string s);
    llts_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.char_code = s[i];
      it.line_end  = 1'b0;
      send_guarded(it);
    end
  endtask

  task automatic send_guarded_char(logic [7:0] c);
    llts_pkg::in_item_t it;
    it.char_code = c;
    it.line_end  = 1'b0;
    send_guarded(it);
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic field_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  task automatic check_result(llts_pkg::result_t got);
    llts_pkg::result_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d char %0h line %0d",
               $time, got.token_kind, got.char_value, got.line_number);
      fail_count++;
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind)
      field_mismatch("token_kind", 64'(want.token_kind), 64'(got.token_kind));
    if (got.char_value !== want.char_value)
      field_mismatch("char_value", 64'(want.char_value), 64'(got.char_value));
    if (got.has_char !== want.has_char)
      field_mismatch("has_char", 64'(want.has_char), 64'(got.has_char));
    if (got.number_value !== want.number_value)
      field_mismatch("number_value", 64'(want.number_value), 64'(got.number_value));
    if (got.last_of_token !== want.last_of_token)
      field_mismatch("last_of_token", 64'(want.last_of_token), 64'(got.last_of_token));
    if (got.line_number !== want.line_number)
      field_mismatch("line_number", 64'(want.line_number), 64'(got.line_number));
    if (got.error_code !== want.error_code)
      field_mismatch("error_code", 64'(want.error_code), 64'(got.error_code));
  endtask

  // Pops results with random stalls and checks each one.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result(result);
    end
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random text pieces
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] random_symbol();
    case ($urandom_range(0, 3))
      0:       return llts_pkg::CH_COMMA;
      1:       return llts_pkg::CH_LPAREN;
      2:       return llts_pkg::CH_RPAREN;
      default: return llts_pkg::CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] random_space();
    if ($urandom_range(0, 5) == 0) return llts_pkg::CH_SPACE;
    return 8'($urandom_range(9, 13));
  endfunction

  // A byte that continues a word; the first byte of a word also avoids digits and quotes.
  function automatic logic [7:0] random_word_byte(bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_space(c) || is_punct(c) || c == llts_pkg::CH_HASH ||
           (first && (c == llts_pkg::CH_QUOTE ||
                      (c >= llts_pkg::CH_ZERO && c <= llts_pkg::CH_NINE))));
    return c;
  endfunction

  function automatic logic [7:0] random_hex_digit();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return llts_pkg::CH_ZERO + 8'(d);
    if ($urandom_range(0, 1) == 1) return llts_pkg::CH_A_UPPER + 8'(d - 10);
    return llts_pkg::CH_A_LOWER + 8'(d - 10);
  endfunction

  task automatic send_random_number();
    case ($urandom_range(0, 5))
      0: begin
        send_guarded_char(8'($urandom_range(49, 57)));
        repeat ($urandom_range(0, 3)) send_guarded_char(8'($urandom_range(48, 57)));
      end
      1: begin
        send_guarded_char(llts_pkg::CH_ZERO);
        send_guarded_char($urandom_range(0, 1) ? llts_pkg::CH_X_UPPER
                                               : llts_pkg::CH_X_LOWER);
        repeat ($urandom_range(1, 16)) send_guarded_char(random_hex_digit());
      end
      2: begin
        send_guarded_char(llts_pkg::CH_ZERO);
        repeat ($urandom_range(0, 5)) send_guarded_char(8'($urandom_range(48, 57)));
      end
      3: begin
        // Largest value that still fits.
        if ($urandom_range(0, 1) == 1) send_text("9223372036854775807");
        else send_text("0x7fffffffffffffff");
      end
      4: begin
        send_guarded_char(8'($urandom_range(49, 57)));
        repeat ($urandom_range(17, 20)) send_guarded_char(8'($urandom_range(48, 57)));
      end
      default: begin
        // One digit, then word bytes that stop the integer early and are folded in.
        send_guarded_char(8'($urandom_range(48, 57)));
        repeat ($urandom_range(1, 4)) send_guarded_char(random_word_byte(1'b0));
      end
    endcase
  endtask

  task automatic send_random_string();
    logic [7:0] c;
    send_guarded_char(llts_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_guarded_char(llts_pkg::CH_BACKSLASH);
        case ($urandom_range(0, 3))
          0:       send_guarded_char(llts_pkg::CH_N_LOWER);
          1:       send_guarded_char(llts_pkg::CH_T_LOWER);
          2:       send_guarded_char(llts_pkg::CH_BACKSLASH);
          default: send_guarded_char(llts_pkg::CH_QUOTE);
        endcase
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == llts_pkg::CH_QUOTE || c == llts_pkg::CH_BACKSLASH);
        send_guarded_char(c);
      end
    end
    send_guarded_char(llts_pkg::CH_QUOTE);
  endtask

  // One token, a comment, a line end, noise or spaces, then a random separator or none.
  task automatic send_random_token();
    llts_pkg::in_item_t it;
    case ($urandom_range(0, 9))
      0, 1: begin
        send_guarded_char(random_word_byte(1'b1));
        repeat ($urandom_range(0, 5)) send_guarded_char(random_word_byte(1'b0));
      end
      2, 3: send_random_number();
      4:    send_random_string();
      5:    send_guarded_char(random_symbol());
      6: begin
        send_guarded_char(llts_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) send_guarded_char(8'($urandom_range(0, 255)));
        send_guarded_eol();
      end
      7:    send_guarded_eol();
      8: begin
        repeat ($urandom_range(1, 4)) begin
          it.char_code = 8'($urandom_range(0, 255));
          it.line_end  = ($urandom_range(0, 7) == 0);
          send_guarded(it);
        end
      end
      default: repeat ($urandom_range(1, 3)) send_guarded_char(random_space());
    endcase
    case ($urandom_range(0, 4))
      0: send_guarded_char(random_space());
      1: send_guarded_char(random_symbol());
      2: send_guarded_eol();
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes 0 and 255 and a quote inside a word, the symbols comma, open paren and dot,
  // a hash that starts a word, and a word ended by the end of the line.
  task automatic test_words_and_symbols();
    send_char(8'h00);
    send_char(8'hFF);
    send_text("\",(.#9 z");
    send_eol();
  endtask

  // Hex ended by a symbol, octal stopped by an invalid digit, a comment right after
  // a number, and a bare 0x prefix.
  task automatic test_numbers();
    send_text("0xF)078#q");
    send_eol();
    send_text("0x ");
  endtask

  // All four escapes, the closing quote not reused, then an empty string.
  task automatic test_strings();
    send_text("\"\\n\\t\\\\\\\"\"\"\"");
  endtask

  task automatic test_random_text();
    int unsigned round_end;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      round_end = items_sent + ROUND_ITEMS;
      while (items_sent < round_end) send_random_token();
      // Hold the sender back until the queue has drained completely.
      if (round == 2 || round == 5) wait_for_results();
    end
    while (lex.mode == llts_pkg::MODE_STRING || lex.mode == llts_pkg::MODE_ESCAPE)
      send_char(lex.mode == llts_pkg::MODE_ESCAPE ? llts_pkg::CH_N_LOWER
                                                  : llts_pkg::CH_QUOTE);
    send_eol();
    wait_for_results();
  endtask

  // Raises one error, picked at random, then checks that later bytes give nothing.
  task automatic test_halt_on_error();
    string              digits;
    logic [7:0]         c;
    llts_pkg::in_item_t it;
    send_text("k ");
    case ($urandom_range(1, 3))
      1: begin
        send_char(llts_pkg::CH_QUOTE);
        send_char(8'h61);
        if ($urandom_range(0, 1) == 1) send_char(llts_pkg::CH_BACKSLASH);
        send_eol();
      end
      2: begin
        send_char(llts_pkg::CH_QUOTE);
        send_char(llts_pkg::CH_BACKSLASH);
        do c = 8'($urandom_range(0, 255));
        while (c == llts_pkg::CH_N_LOWER || c == llts_pkg::CH_T_LOWER ||
               c == llts_pkg::CH_BACKSLASH || c == llts_pkg::CH_QUOTE);
        send_char(c);
      end
      default: begin
        if ($urandom_range(0, 1) == 1) digits = "9223372036854775808";
        else digits = "0x8000000000000000";
        for (int i = 0; i < digits.len(); i++) send_char(digits[i]);
        case ($urandom_range(0, 3))
          0:       send_char(llts_pkg::CH_SPACE);
          1:       send_char(random_symbol());
          2:       send_char(llts_pkg::CH_HASH);
          default: send_eol();
        endcase
      end
    endcase
    repeat (20) begin
      it.char_code = 8'($urandom_range(0, 255));
      it.line_end  = ($urandom_range(0, 3) == 0);
      send_item(it);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    clear_lexer();
    test_words_and_symbols();
    test_numbers();
    test_strings();
    wait_for_results();
    test_random_text();
    test_halt_on_error();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/llts_pkg.sv
hdl/llts_front.sv
hdl/llts_queue.sv
hdl/line_lexer_token_stream_core.sv
hdl/llts_checker.sv
tb/tb_line_lexer_token_stream_core.sv
